/* hdl/eac_pkg.sv */
// Package for the coalescing extent allocator.
// Holds table sizes, operation and status codes, register indexes and the entry type.
// No dependencies.
`default_nettype none
package eac_pkg;

  localparam int ENTRIES = 2048;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int KIND_W = 3;
  localparam int OIDX_W = 11;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREE   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RECORD = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRIM   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_INIT   = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FREE_ERR = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NO_ENTRY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EXHAUST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_END = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRIM    = 2'd1;

  localparam logic [31:0] INITIAL_END_RST = 32'd65640;
  localparam logic [31:0] MIN_TRIM_RST    = 32'd1024;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] len;
    logic        used;
  } ent_t;

endpackage
`default_nettype wire

/* hdl/eac_if.sv */
// Channel interfaces for the coalescing extent allocator.
// Request, response and configuration channels; depends on eac_pkg.
`default_nettype none
interface eac_req_if import eac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [31:0]       req_offset;
  logic [31:0]       req_length;
  logic [10:0]       req_index;
  modport source (output valid, kind, req_offset, req_length, req_index, input ready);
  modport sink (input valid, kind, req_offset, req_length, req_index, output ready);
endinterface

interface eac_rsp_if import eac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [31:0]       out_offset;
  logic [OIDX_W-1:0] out_index;
  modport source (output valid, status, out_offset, out_index, input ready);
  modport sink (input valid, status, out_offset, out_index, output ready);
endinterface

interface eac_cfg_if import eac_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/extent_allocator_coalescing.sv */
// Coalescing first-fit extent allocator: control sequencer and extent table memory.
// Depends on eac_pkg and the channel interfaces in eac_if.
//
// Allocate, record, free, delete and trim walk the extent table, held in a memory with
// one synchronous read port and one write port, one entry per cycle; the walk restarts
// after each merge. Delete and trim first read the indexed entry.
// After reset and on init the table is cleared in a pass over all entries,
// during which no request is taken. Configuration writes are always taken.
`default_nettype none
module extent_allocator_coalescing import eac_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  eac_req_if.sink   req,
  eac_rsp_if.source rsp,
  eac_cfg_if.sink   cfg
);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_CLR     = 7'b0000010,
    ST_SCAN    = 7'b0000100,
    ST_IDX_RD  = 7'b0001000,
    ST_IDX_DAT = 7'b0010000,
    ST_FIN     = 7'b0100000,
    ST_RESP    = 7'b1000000
  } state_t;

  ent_t mem [ENTRIES];
  ent_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  ent_t wr_data;

  state_t state, state_next;
  logic [KIND_W-1:0] op, op_next;
  logic [31:0] r_off, r_off_next, r_len, r_len_next;
  logic [10:0] r_idx, r_idx_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic d_vld, d_vld_next;
  logic [IDX_W-1:0] d_idx, d_idx_next;
  logic [32:0] reg_start, reg_start_next, reg_end, reg_end_next;
  logic emp_found, emp_found_next;
  logic [IDX_W-1:0] emp_idx, emp_idx_next;
  logic [31:0] ep, ep_next;
  logic clr_resp, clr_resp_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic [31:0] res_off, res_off_next;
  logic [OIDX_W-1:0] res_idx, res_idx_next;
  logic o_valid, o_valid_next;
  logic [STAT_W-1:0] o_status, o_status_next;
  logic [31:0] o_off, o_off_next;
  logic [OIDX_W-1:0] o_idx, o_idx_next;
  logic [31:0] initial_end, min_trim;

  logic is_free, is_empty, alloc_hit, mrg_left, mrg_right, last, issue;
  logic [32:0] e_end, ep_sum;
  logic [31:0] new_len;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_end <= INITIAL_END_RST;
      min_trim <= MIN_TRIM_RST;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_INITIAL_END) begin
        initial_end <= cfg.data;
      end else if (cfg.index == CFG_MIN_TRIM) begin
        min_trim <= cfg.data;
      end
    end
  end
  assign cfg.ready = 1'b1;

  assign is_free = (rd_data.off != 32'd0) && !rd_data.used;
  assign is_empty = (rd_data == '0);
  assign e_end = {1'b0, rd_data.off} + {1'b0, rd_data.len};
  assign alloc_hit = is_free && (rd_data.len >= r_len);
  assign mrg_left = is_free && (e_end == reg_start);
  assign mrg_right = is_free && ({1'b0, rd_data.off} == reg_end);
  assign last = (d_idx == IDX_W'(ENTRIES - 1));
  assign new_len = rd_data.len - r_len;
  assign ep_sum = {1'b0, ep} + {1'b0, r_len};
  assign issue = (state == ST_SCAN) && (ptr < CNT_W'(ENTRIES));

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = o_valid;
  assign rsp.status = o_status;
  assign rsp.out_offset = o_off;
  assign rsp.out_index = o_idx;

  always_comb begin
    state_next = state;
    op_next = op;
    r_off_next = r_off;
    r_len_next = r_len;
    r_idx_next = r_idx;
    ptr_next = ptr;
    d_vld_next = 1'b0;
    d_idx_next = d_idx;
    reg_start_next = reg_start;
    reg_end_next = reg_end;
    emp_found_next = emp_found;
    emp_idx_next = emp_idx;
    ep_next = ep;
    clr_resp_next = clr_resp;
    res_status_next = res_status;
    res_off_next = res_off;
    res_idx_next = res_idx;
    o_valid_next = o_valid && !rsp.ready;
    o_status_next = o_status;
    o_off_next = o_off;
    o_idx_next = o_idx;
    rd_addr = ptr[IDX_W-1:0];
    wr_en = 1'b0;
    wr_addr = d_idx;
    wr_data = '0;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          op_next = req.kind;
          r_off_next = req.req_offset;
          r_len_next = req.req_length;
          r_idx_next = req.req_index;
          res_status_next = STAT_OK;
          res_off_next = '0;
          res_idx_next = '0;
          ptr_next = '0;
          emp_found_next = 1'b0;
          reg_start_next = {1'b0, req.req_offset};
          reg_end_next = {1'b0, req.req_offset} + {1'b0, req.req_length};
          case (req.kind)
            KIND_ALLOC, KIND_FREE, KIND_RECORD: state_next = ST_SCAN;
            KIND_DELETE, KIND_TRIM: begin
              if (32'(req.req_index) < 32'(ENTRIES)) begin
                state_next = ST_IDX_RD;
              end else begin
                state_next = ST_RESP;
              end
            end
            KIND_INIT: begin
              ep_next = initial_end;
              clr_resp_next = 1'b1;
              state_next = ST_CLR;
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_CLR: begin
        wr_en = 1'b1;
        wr_addr = ptr[IDX_W-1:0];
        ptr_next = CNT_W'(ptr + 1'b1);
        if (ptr == CNT_W'(ENTRIES - 1)) begin
          state_next = clr_resp ? ST_RESP : ST_IDLE;
        end
      end
      ST_IDX_RD: begin
        rd_addr = IDX_W'(32'(r_idx));
        state_next = ST_IDX_DAT;
      end
      ST_IDX_DAT: begin
        wr_addr = IDX_W'(32'(r_idx));
        reg_end_next = e_end;
        ptr_next = '0;
        emp_found_next = 1'b0;
        if (op == KIND_DELETE) begin
          wr_en = 1'b1;
          reg_start_next = {1'b0, rd_data.off};
          state_next = ST_SCAN;
        end else if ((r_len < rd_data.len) && (new_len >= min_trim)) begin
          wr_en = 1'b1;
          wr_data = '{off: rd_data.off, len: r_len, used: rd_data.used};
          reg_start_next = {1'b0, rd_data.off} + {1'b0, r_len};
          state_next = ST_SCAN;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          ptr_next = CNT_W'(ptr + 1'b1);
          d_idx_next = ptr[IDX_W-1:0];
          d_vld_next = 1'b1;
        end
        if (d_vld) begin
          if (op == KIND_ALLOC) begin
            if (alloc_hit) begin
              wr_en = 1'b1;
              if (new_len != 32'd0) begin
                wr_data = '{off: rd_data.off + r_len, len: new_len, used: rd_data.used};
              end
              res_off_next = rd_data.off;
              d_vld_next = 1'b0;
              state_next = ST_RESP;
            end else if (last) begin
              state_next = ST_FIN;
            end
          end else if (op == KIND_RECORD) begin
            if (is_empty) begin
              wr_en = 1'b1;
              wr_data = '{off: r_off, len: r_len, used: 1'b1};
              res_idx_next = OIDX_W'(32'(d_idx));
              d_vld_next = 1'b0;
              state_next = ST_RESP;
            end else if (last) begin
              res_status_next = STAT_NO_ENTRY;
              state_next = ST_RESP;
            end
          end else begin
            if (mrg_left || mrg_right) begin
              wr_en = 1'b1;
              if (mrg_left) begin
                reg_start_next = {1'b0, rd_data.off};
              end else begin
                reg_end_next = e_end;
              end
              ptr_next = '0;
              emp_found_next = 1'b0;
              d_vld_next = 1'b0;
            end else begin
              if (is_empty && !emp_found) begin
                emp_found_next = 1'b1;
                emp_idx_next = d_idx;
              end
              if (last) begin
                state_next = ST_FIN;
              end
            end
          end
        end
      end
      ST_FIN: begin
        state_next = ST_RESP;
        if (op == KIND_ALLOC) begin
          if (ep_sum[32]) begin
            res_status_next = STAT_EXHAUST;
          end else begin
            res_off_next = ep;
            ep_next = ep_sum[31:0];
          end
        end else if (reg_end > {1'b0, ep}) begin
          res_status_next = STAT_FREE_ERR;
        end else if (reg_end == {1'b0, ep}) begin
          ep_next = reg_start[31:0];
        end else if (emp_found) begin
          wr_en = 1'b1;
          wr_addr = emp_idx;
          wr_data = '{off: reg_start[31:0], len: 32'(reg_end - reg_start), used: 1'b0};
        end else begin
          res_status_next = STAT_NO_ENTRY;
        end
      end
      ST_RESP: begin
        if (!o_valid || rsp.ready) begin
          o_valid_next = 1'b1;
          o_status_next = res_status;
          o_off_next = res_off;
          o_idx_next = res_idx;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      ptr <= '0;
      clr_resp <= 1'b0;
      ep <= INITIAL_END_RST;
      o_valid <= 1'b0;
      d_vld <= 1'b0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      clr_resp <= clr_resp_next;
      ep <= ep_next;
      o_valid <= o_valid_next;
      d_vld <= d_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    r_off <= r_off_next;
    r_len <= r_len_next;
    r_idx <= r_idx_next;
    d_idx <= d_idx_next;
    reg_start <= reg_start_next;
    reg_end <= reg_end_next;
    emp_found <= emp_found_next;
    emp_idx <= emp_idx_next;
    res_status <= res_status_next;
    res_off <= res_off_next;
    res_idx <= res_idx_next;
    o_status <= o_status_next;
    o_off <= o_off_next;
    o_idx <= o_idx_next;
  end

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state != ST_IDLE))
    else $error("Accepted request did not start an operation.");

  a_no_req_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLR) |-> !req.ready)
    else $error("Request taken during the clearing pass.");

  a_exhaust_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status == STAT_EXHAUST)) |-> (rsp.out_offset == 32'd0))
    else $error("Exhausted allocation reported a nonzero offset.");

endmodule
`default_nettype wire
